FILE: design/sylk_pkg.sv
// shared types and constants for the sylk cell extractor
`timescale 1ns / 1ps

package sylk_pkg;

   localparam int FIELD_CAPACITY = 1024;
   localparam int LEN_WIDTH = $clog2(FIELD_CAPACITY) + 1;
   localparam int NUM_WIDTH = 16;

   localparam logic [LEN_WIDTH-1:0] LEN_LIMIT = LEN_WIDTH'(FIELD_CAPACITY - 1);
   localparam logic [NUM_WIDTH-1:0] NUM_MAX = '1;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_K     = 8'h4B;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_Y     = 8'h59;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [1:0] {
      LP_START,
      LP_AFTER_TYPE,
      LP_FIELDS,
      LP_SKIP
   } line_phase_type;

   typedef enum logic [2:0] {
      FP_START,
      FP_K_FIRST,
      FP_K_PLAIN,
      FP_K_QUOTED,
      FP_K_QPEND,
      FP_X_NUM,
      FP_Y_NUM,
      FP_OTHER
   } field_phase_type;

endpackage

FILE: design/sylk_cell_extractor.sv
// sylk cell extractor: streams cell text bytes and cell ends out of a sylk buffer
//
// Takes one buffer byte per cycle and gives at most one result per byte, registered as
// the byte is taken: either a decoded text byte of a K field in a C record or the end of
// that cell, tagged with the current column and row. A zero byte ends the buffer, closes
// an open cell and returns the parser to its reset state. All per-byte work is a single
// pass through the parser state; a result register with its own valid decouples the two
// sides, so a new byte is taken each cycle unless a waiting result is stalled.
`timescale 1ns / 1ps

module sylk_cell_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [15:0] rsp_cell_column,
   output logic [15:0] rsp_cell_row
);

   sylk_pkg::line_phase_type  line_ff, line_in;
   sylk_pkg::field_phase_type field_ff, field_in;
   logic                      is_cell_ff, is_cell_in;
   logic [15:0]               col_ff, col_in;
   logic [15:0]               row_ff, row_in;
   logic [15:0]               acc_ff, acc_in;
   logic [sylk_pkg::LEN_WIDTH-1:0] len_ff, len_in;
   logic                      emit_ff, emit_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [15:0] out_col_ff, out_col_in;
   logic [15:0] out_row_ff, out_row_in;

   logic        accept;
   logic [7:0]  b;
   logic        is_k;
   logic        do_field, do_end, do_start, do_put, fire, fire_kind;
   logic        len_ok, is_digit;
   logic [19:0] acc_wide;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_in_byte;

   assign is_k = (field_ff == sylk_pkg::FP_K_FIRST) || (field_ff == sylk_pkg::FP_K_PLAIN) ||
                 (field_ff == sylk_pkg::FP_K_QUOTED) || (field_ff == sylk_pkg::FP_K_QPEND);
   assign len_ok   = len_ff < sylk_pkg::LEN_LIMIT;
   assign is_digit = (b >= sylk_pkg::CH_ZERO) && (b <= sylk_pkg::CH_NINE);
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                     {16'b0, b[3:0]};

   always_comb begin
      line_in    = line_ff;
      field_in   = field_ff;
      is_cell_in = is_cell_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      acc_in     = acc_ff;
      len_in     = len_ff;
      emit_in    = emit_ff;
      do_field   = 1'b0;
      do_end     = 1'b0;
      do_start   = 1'b0;
      do_put     = 1'b0;
      fire       = 1'b0;
      fire_kind  = sylk_pkg::KIND_TEXT;

      // line level
      if (b == sylk_pkg::CH_NUL || b == sylk_pkg::CH_CR || b == sylk_pkg::CH_LF) begin
         do_end  = (line_ff == sylk_pkg::LP_FIELDS);
         line_in = sylk_pkg::LP_START;
      end else begin
         unique case (line_ff)
            sylk_pkg::LP_START: begin
               if (b == sylk_pkg::CH_C || b == sylk_pkg::CH_F) begin
                  is_cell_in = (b == sylk_pkg::CH_C);
                  line_in    = sylk_pkg::LP_AFTER_TYPE;
               end else begin
                  line_in = sylk_pkg::LP_SKIP;
               end
            end
            sylk_pkg::LP_AFTER_TYPE: begin
               line_in = sylk_pkg::LP_FIELDS;
               do_start = (b != sylk_pkg::CH_SEMI);
            end
            sylk_pkg::LP_FIELDS: do_field = 1'b1;
            default: ;
         endcase
      end

      // field level
      if (do_field) begin
         unique case (field_ff)
            sylk_pkg::FP_START: do_start = 1'b1;
            sylk_pkg::FP_K_FIRST: begin
               if (b == sylk_pkg::CH_QUOTE) begin
                  field_in = sylk_pkg::FP_K_QUOTED;
               end else if (b == sylk_pkg::CH_SEMI) begin
                  do_end = 1'b1;
               end else begin
                  field_in = sylk_pkg::FP_K_PLAIN;
                  do_put   = 1'b1;
               end
            end
            sylk_pkg::FP_K_PLAIN: begin
               if (b == sylk_pkg::CH_SEMI) begin
                  do_end = 1'b1;
               end else begin
                  do_put = 1'b1;
               end
            end
            sylk_pkg::FP_K_QUOTED: begin
               if (b == sylk_pkg::CH_QUOTE) begin
                  field_in = sylk_pkg::FP_K_QPEND;
               end else begin
                  do_put = 1'b1;
               end
            end
            sylk_pkg::FP_K_QPEND: begin
               if (b == sylk_pkg::CH_QUOTE) begin
                  field_in = sylk_pkg::FP_K_QUOTED;
                  do_put   = 1'b1;
               end else begin
                  do_end   = 1'b1;
                  do_start = (b != sylk_pkg::CH_SEMI);
               end
            end
            sylk_pkg::FP_X_NUM, sylk_pkg::FP_Y_NUM: begin
               if (b == sylk_pkg::CH_SEMI) begin
                  do_end = 1'b1;
               end else if (len_ok && is_digit) begin
                  len_in = len_ff + 1'b1;
                  acc_in = (acc_wide > {4'b0, sylk_pkg::NUM_MAX}) ? sylk_pkg::NUM_MAX
                                                                 : acc_wide[15:0];
               end else begin
                  // value is final, rest of the field is ignored
                  if (field_ff == sylk_pkg::FP_X_NUM) begin
                     col_in = acc_ff;
                  end else begin
                     row_in = acc_ff;
                  end
                  field_in = sylk_pkg::FP_OTHER;
               end
            end
            default: begin
               if (b == sylk_pkg::CH_SEMI) begin
                  field_in = sylk_pkg::FP_START;
               end
            end
         endcase
      end

      if (do_end) begin
         if (is_k) begin
            fire      = emit_ff;
            fire_kind = sylk_pkg::KIND_END;
            emit_in   = 1'b0;
         end else if (field_ff == sylk_pkg::FP_X_NUM) begin
            col_in = acc_ff;
         end else if (field_ff == sylk_pkg::FP_Y_NUM) begin
            row_in = acc_ff;
         end
         field_in = sylk_pkg::FP_START;
      end

      if (do_start) begin
         len_in = sylk_pkg::LEN_WIDTH'(1);
         acc_in = '0;
         priority if (b == sylk_pkg::CH_K) begin
            emit_in  = is_cell_ff && (col_ff != '0) && (row_ff != '0);
            field_in = sylk_pkg::FP_K_FIRST;
         end else if (b == sylk_pkg::CH_X) begin
            field_in = sylk_pkg::FP_X_NUM;
         end else if (b == sylk_pkg::CH_Y) begin
            field_in = sylk_pkg::FP_Y_NUM;
         end else begin
            field_in = sylk_pkg::FP_OTHER;
         end
      end

      if (do_put && len_ok) begin
         len_in = len_ff + 1'b1;
         fire   = emit_ff;
      end

      // end of buffer or line overrides field state
      if (b == sylk_pkg::CH_NUL) begin
         line_in    = sylk_pkg::LP_START;
         field_in   = sylk_pkg::FP_START;
         is_cell_in = 1'b0;
         col_in     = 16'd1;
         row_in     = 16'd1;
         acc_in     = '0;
         len_in     = '0;
         emit_in    = 1'b0;
      end else if (b == sylk_pkg::CH_CR || b == sylk_pkg::CH_LF) begin
         field_in = sylk_pkg::FP_START;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & rsp_stall;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      if (accept && fire) begin
         out_valid_in = 1'b1;
         out_kind_in  = fire_kind;
         out_byte_in  = (fire_kind == sylk_pkg::KIND_END) ? 8'h00 : b;
         out_col_in   = col_ff;
         out_row_in   = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= sylk_pkg::LP_START;
         field_ff     <= sylk_pkg::FP_START;
         is_cell_ff   <= 1'b0;
         col_ff       <= 16'd1;
         row_ff       <= 16'd1;
         acc_ff       <= '0;
         len_ff       <= '0;
         emit_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            line_ff    <= line_in;
            field_ff   <= field_in;
            is_cell_ff <= is_cell_in;
            col_ff     <= col_in;
            row_ff     <= row_in;
            acc_ff     <= acc_in;
            len_ff     <= len_in;
            emit_ff    <= emit_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_text_byte   = out_byte_ff;
   assign rsp_cell_column = out_col_ff;
   assign rsp_cell_row    = out_row_ff;

   // a cell end carries no text
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sylk_pkg::KIND_END |-> rsp_text_byte == 8'h00)
      else $error("cell end with nonzero text byte");

   // results only come from cells with a valid position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_column != 16'd0 && rsp_cell_row != 16'd0)
      else $error("result with zero column or row");

   // emitting only inside a k field
   assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> is_k && line_ff == sylk_pkg::LP_FIELDS)
      else $error("emitting outside a k field");

   // field length stays within capacity
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= sylk_pkg::LEN_LIMIT)
      else $error("field length beyond capacity");

   // a buffer end leaves the parser in its reset state
   assert property (@(posedge clock) disable iff (reset)
      accept && req_in_byte == sylk_pkg::CH_NUL |=>
         line_ff == sylk_pkg::LP_START && !emit_ff && col_ff == 16'd1 && row_ff == 16'd1)
      else $error("buffer end did not reset parser");

endmodule
